// File: sv/pot_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the perceptron online trainer.
// No dependencies; all other files but pot_merge refer to this package.
package pot_pkg;

  // Default sizes of the trained model
  localparam int NUM_FEATURES_DEF = 16;
  localparam int FEATURE_BITS_DEF = 4;
  localparam int WEIGHT_BITS_DEF  = 32;

  // Fixed field widths of the channels
  localparam int FEAT_WORD_BITS = 64;
  localparam int LOAD_BITS      = 32;
  localparam int INDEX_BITS     = 5;
  localparam int RATE_BITS      = 16;
  localparam int CNT_BITS       = 16;
  localparam int TOL_BITS       = 10;
  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_IDX_BITS   = 2;

  // Stop rule compares 1000 * delta against tolerance * N
  localparam int STOP_SCALE     = 1000;
  localparam int STOP_BITS      = CNT_BITS + TOL_BITS;

  // Configuration reset values
  localparam logic [RATE_BITS-1:0] RATE_RST     = 16'd13107;
  localparam logic [CNT_BITS-1:0]  EPOCH_N_RST  = 16'd1000;
  localparam logic [CNT_BITS-1:0]  MAX_EP_RST   = 16'd11000;
  localparam logic [TOL_BITS-1:0]  TOL_RST      = 10'd1;

  // Input opcodes
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_EXAMPLE = 1'b1;

  // Output word kinds
  localparam logic KIND_VERDICT = 1'b0;
  localparam logic KIND_WEIGHT  = 1'b1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_LEARNING_RATE = 2'd0,
    CFG_EPOCH_LEN     = 2'd1,
    CFG_MAX_EPOCHS    = 2'd2,
    CFG_TOLERANCE     = 2'd3
  } cfg_idx_e;

  // Training status
  typedef enum logic [1:0] {
    ST_TRAIN = 2'd0,
    ST_DONE  = 2'd1,
    ST_FAIL  = 2'd2
  } run_status_e;

  // Commands broadcast to every lane
  typedef struct packed {
    logic load;     // write one weight slot and its prior copy
    logic capture;  // register product and step for a new example
    logic update;   // apply the step (miss)
    logic add;      // step direction: 1 adds, 0 subtracts
    logic copy;     // snapshot the (updated) weight into the prior copy
  } lane_ctl_t;

  // One result word
  typedef struct packed {
    logic                  kind;
    logic                  correct;
    logic                  epoch_end;
    logic [CNT_BITS-1:0]   epoch_correct;
    logic                  gave_up;
    logic [INDEX_BITS-1:0] weight_index;
    logic [LOAD_BITS-1:0]  weight_out;
    logic                  last;
  } out_word_t;

endpackage

// File: sv/pot_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the perceptron online trainer.
// Depends on pot_pkg for field widths.
interface pot_in_if;
  logic                                    valid;
  logic                                    ready;
  logic                                    op;
  logic [pot_pkg::FEAT_WORD_BITS-1:0]      features;
  logic                                    is_positive;
  logic [pot_pkg::INDEX_BITS-1:0]          load_index;
  logic signed [pot_pkg::LOAD_BITS-1:0]    load_value;

  modport source (
    output valid, op, features, is_positive, load_index, load_value,
    input  ready
  );
  modport sink (
    input  valid, op, features, is_positive, load_index, load_value,
    output ready
  );
endinterface

interface pot_out_if;
  logic                                    valid;
  logic                                    ready;
  logic                                    kind;
  logic                                    correct;
  logic                                    epoch_end;
  logic [pot_pkg::CNT_BITS-1:0]            epoch_correct;
  logic                                    gave_up;
  logic [pot_pkg::INDEX_BITS-1:0]          weight_index;
  logic signed [pot_pkg::LOAD_BITS-1:0]    weight_out;
  logic                                    last;

  modport source (
    output valid, kind, correct, epoch_end, epoch_correct, gave_up,
           weight_index, weight_out, last,
    input  ready
  );
  modport sink (
    input  valid, kind, correct, epoch_end, epoch_correct, gave_up,
           weight_index, weight_out, last,
    output ready
  );
endinterface

// File: sv/pot_lane.sv
`timescale 1ns / 1ps
// One weight lane: holds a weight and its prior-epoch copy, forms w*x and
// the update step, and applies the saturating update. Depends on pot_pkg.
module pot_lane #(
  parameter int WEIGHT_BITS  = pot_pkg::WEIGHT_BITS_DEF,
  parameter int FEATURE_BITS = pot_pkg::FEATURE_BITS_DEF,
  parameter int LANE_IDX     = 0
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  pot_pkg::lane_ctl_t                     ctl_i,
  input  logic [FEATURE_BITS-1:0]                x_i,
  input  logic [pot_pkg::RATE_BITS-1:0]          rate_i,
  input  logic [pot_pkg::INDEX_BITS-1:0]         load_index_i,
  input  logic signed [WEIGHT_BITS-1:0]          load_value_i,
  output logic signed [WEIGHT_BITS+FEATURE_BITS:0] prod_o,
  output logic signed [WEIGHT_BITS-1:0]          weight_o,
  output logic signed [WEIGHT_BITS-1:0]          prior_o
);

  localparam int PW = WEIGHT_BITS + FEATURE_BITS + 1;
  localparam int DW = pot_pkg::RATE_BITS + FEATURE_BITS;
  localparam int SW = ((WEIGHT_BITS > DW) ? WEIGHT_BITS : DW) + 2;
  localparam logic signed [SW-1:0] W_MAX =
    {{(SW-WEIGHT_BITS+1){1'b0}}, {(WEIGHT_BITS-1){1'b1}}};
  localparam logic signed [SW-1:0] W_MIN =
    {{(SW-WEIGHT_BITS+1){1'b1}}, {(WEIGHT_BITS-1){1'b0}}};
  localparam logic [pot_pkg::INDEX_BITS-1:0] MY_IDX = pot_pkg::INDEX_BITS'(LANE_IDX);

  logic signed [WEIGHT_BITS-1:0] w_q, w_d, prior_q, prior_d, w_upd;
  logic signed [PW-1:0]          prod_q;
  logic [DW-1:0]                 delta_q;
  logic signed [FEATURE_BITS:0]  x_s;
  logic signed [SW-1:0]          w_ext, d_ext, sum;

  assign x_s = {1'b0, x_i};

  // product and step for the example entering stage 1
  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      prod_q  <= PW'(w_q) * PW'(x_s);
      delta_q <= DW'(rate_i) * DW'(x_i);
    end
  end

  // saturating update
  always_comb begin
    w_ext = SW'(w_q);
    d_ext = SW'(delta_q);
    sum   = ctl_i.add ? (w_ext + d_ext) : (w_ext - d_ext);
    if (sum > W_MAX) begin
      w_upd = WEIGHT_BITS'(W_MAX);
    end else if (sum < W_MIN) begin
      w_upd = WEIGHT_BITS'(W_MIN);
    end else begin
      w_upd = WEIGHT_BITS'(sum);
    end
  end

  // next weight and prior copy; copy takes the updated weight
  always_comb begin
    w_d     = w_q;
    prior_d = prior_q;
    if (ctl_i.load && load_index_i == MY_IDX) begin
      w_d     = load_value_i;
      prior_d = load_value_i;
    end else begin
      if (ctl_i.update) begin
        w_d = w_upd;
      end
      if (ctl_i.copy) begin
        prior_d = w_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q     <= '0;
      prior_q <= '0;
    end else begin
      w_q     <= w_d;
      prior_q <= prior_d;
    end
  end

  assign prod_o   = prod_q;
  assign weight_o = w_q;
  assign prior_o  = prior_q;

endmodule

// File: sv/pot_merge.sv
`timescale 1ns / 1ps
// Merge stage: adder tree over the lane products and the sign decision.
// Depends on nothing but its parameters.
module pot_merge #(
  parameter int NUM_LANES = 17,
  parameter int PROD_BITS = 37
) (
  input  logic signed [PROD_BITS-1:0] prod_i [NUM_LANES],
  output logic                        nonneg_o
);

  localparam int LEVELS   = (NUM_LANES > 1) ? $clog2(NUM_LANES) : 1;
  localparam int LEAVES   = 1 << LEVELS;
  localparam int ACC_BITS = PROD_BITS + LEVELS;

  logic signed [ACC_BITS-1:0] node [LEVELS+1][LEAVES];

  // balanced tree, unused leaves are zero
  always_comb begin
    for (int l = 0; l <= LEVELS; l++) begin
      for (int i = 0; i < LEAVES; i++) begin
        node[l][i] = '0;
      end
    end
    for (int i = 0; i < NUM_LANES; i++) begin
      node[0][i] = ACC_BITS'(prod_i[i]);
    end
    for (int l = 0; l < LEVELS; l++) begin
      for (int i = 0; i < (LEAVES >> (l + 1)); i++) begin
        node[l+1][i] = node[l][2*i] + node[l][2*i+1];
      end
    end
    // zero counts as the positive class
    nonneg_o = !node[LEVELS][0][ACC_BITS-1];
  end

endmodule

// File: sv/perceptron_online_trainer.sv
`timescale 1ns / 1ps
// Top level of the perceptron online trainer: config registers, epoch
// bookkeeping, lanes, merge and output register. Depends on pot_pkg, pot_if,
// pot_lane and pot_merge.
//
//  channel   dir  payload                                   word moves on
//  cfg_*     in   index, 16-bit data                        cfg_we_i high
//  in_i      in   op, features, is_positive, load_index/val valid && ready
//  out_o     out  kind, verdict fields, weight_index/out    valid && ready
//
// An example forms the lane products in the first stage and the adder tree,
// verdict and weight update in the second; the weights of one example feed
// the next, so a new example is taken only after the last leaves the second
// stage. A stop adds one weight word per cycle while the output is free (17
// at the default size); input is held until the last one is in the output
// register. Reset clears weights, counters and status at once; there is no
// sweep. A stalled output holds the second stage and with it the input.
module perceptron_online_trainer #(
  parameter int NUM_FEATURES = pot_pkg::NUM_FEATURES_DEF,
  parameter int FEATURE_BITS = pot_pkg::FEATURE_BITS_DEF,
  parameter int WEIGHT_BITS  = pot_pkg::WEIGHT_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pot_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  logic [pot_pkg::CFG_DATA_BITS-1:0]   cfg_wdata_i,
  pot_in_if.sink                              in_i,
  pot_out_if.source                           out_o
);

  localparam int NL     = NUM_FEATURES + 1;
  localparam int PW     = WEIGHT_BITS + FEATURE_BITS + 1;
  localparam int EIDX_W = $clog2(NL);
  localparam int CW     = pot_pkg::CNT_BITS;
  localparam int SB     = pot_pkg::STOP_BITS;
  localparam logic signed [63:0] W_MAX64 = (64'sd1 <<< (WEIGHT_BITS - 1)) - 64'sd1;
  localparam logic signed [63:0] W_MIN64 = -(64'sd1 <<< (WEIGHT_BITS - 1));
  localparam logic [EIDX_W-1:0]  EIDX_LAST = EIDX_W'(NL - 1);

  // configuration registers
  logic [pot_pkg::RATE_BITS-1:0] rate_q;
  logic [CW-1:0]                 epoch_n_q, max_ep_q;
  logic [pot_pkg::TOL_BITS-1:0]  tol_q;
  logic [SB-1:0]                 tol_n_q;
  logic [CW-1:0]                 n_eff, me_eff;

  // training state
  logic                          s1_q, pos_q;
  logic [CW-1:0]                 ecc_q, pcc_q, ex_q, ep_q;
  pot_pkg::run_status_e          status_q, status_d;
  logic                          emit_q;
  logic [EIDX_W-1:0]             emit_idx_q;
  logic                          out_valid_q;
  pot_pkg::out_word_t            out_q, out_d;

  // lane signals
  pot_pkg::lane_ctl_t            ctl;
  logic signed [PW-1:0]          prod [NL];
  logic signed [WEIGHT_BITS-1:0] weight [NL];
  logic signed [WEIGHT_BITS-1:0] prior [NL];
  logic signed [WEIGHT_BITS-1:0] load_sat;
  logic signed [63:0]            load_ext, wsel_ext;
  logic                          nonneg;

  // handshake and stage control
  logic                          in_ready, in_acc, out_free, fire, emit_step, emit_last;
  logic                          correct, ended, stop, gave, rose;
  logic                          stop_hit, stop_miss, rose_hit, rose_miss;
  logic [CW-1:0]                 closed, ex_next, ep_next, cnt_hit, diff_hit, diff_miss;
  logic [SB-1:0]                 scaled_hit, scaled_miss;

  // config write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q    <= pot_pkg::RATE_RST;
      epoch_n_q <= pot_pkg::EPOCH_N_RST;
      max_ep_q  <= pot_pkg::MAX_EP_RST;
      tol_q     <= pot_pkg::TOL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        pot_pkg::CFG_LEARNING_RATE: rate_q    <= cfg_wdata_i;
        pot_pkg::CFG_EPOCH_LEN:     epoch_n_q <= cfg_wdata_i;
        pot_pkg::CFG_MAX_EPOCHS:    max_ep_q  <= cfg_wdata_i;
        pot_pkg::CFG_TOLERANCE:     tol_q     <= cfg_wdata_i[pot_pkg::TOL_BITS-1:0];
        default: ;
      endcase
    end
  end

  // zero epoch length or limit acts as one
  assign n_eff  = (epoch_n_q == '0) ? CW'(1) : epoch_n_q;
  assign me_eff = (max_ep_q == '0) ? CW'(1) : max_ep_q;

  // stop threshold, registered from the tolerance and epoch length
  always_ff @(posedge clk_i) begin
    tol_n_q <= SB'(tol_q) * SB'(n_eff);
  end

  // input side
  assign in_ready  = !s1_q && !emit_q;
  assign in_i.ready = in_ready;
  assign in_acc    = in_i.valid && in_ready;
  assign out_free  = !out_valid_q || out_o.ready;
  assign fire      = s1_q && out_free;
  assign emit_step = emit_q && out_free;
  assign emit_last = (emit_idx_q == EIDX_LAST);

  // load value clamped to the weight range
  always_comb begin
    load_ext = 64'(in_i.load_value);
    if (load_ext > W_MAX64) begin
      load_sat = WEIGHT_BITS'(W_MAX64);
    end else if (load_ext < W_MIN64) begin
      load_sat = WEIGHT_BITS'(W_MIN64);
    end else begin
      load_sat = WEIGHT_BITS'(load_ext);
    end
  end

  // lanes: lane 0 is the bias with a constant feature of one
  for (genvar k = 0; k < NL; k++) begin : g_lane
    logic [FEATURE_BITS-1:0] x;
    if (k == 0) begin : g_bias
      assign x = FEATURE_BITS'(1);
    end else begin : g_feat
      assign x = in_i.features[FEATURE_BITS*(k-1) +: FEATURE_BITS];
    end
    pot_lane #(
      .WEIGHT_BITS (WEIGHT_BITS),
      .FEATURE_BITS(FEATURE_BITS),
      .LANE_IDX    (k)
    ) u_lane (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .x_i         (x),
      .rate_i      (rate_q),
      .load_index_i(in_i.load_index),
      .load_value_i(load_sat),
      .prod_o      (prod[k]),
      .weight_o    (weight[k]),
      .prior_o     (prior[k])
    );
  end

  pot_merge #(
    .NUM_LANES(NL),
    .PROD_BITS(PW)
  ) u_merge (
    .prod_i  (prod),
    .nonneg_o(nonneg)
  );

  // stop rule for both verdicts, worked out from registers beside the tree
  always_comb begin
    cnt_hit     = (ecc_q != '1) ? ecc_q + CW'(1) : ecc_q;
    diff_hit    = (cnt_hit >= pcc_q) ? cnt_hit - pcc_q : pcc_q - cnt_hit;
    diff_miss   = (ecc_q >= pcc_q) ? ecc_q - pcc_q : pcc_q - ecc_q;
    scaled_hit  = SB'(diff_hit) * SB'(pot_pkg::STOP_SCALE);
    scaled_miss = SB'(diff_miss) * SB'(pot_pkg::STOP_SCALE);
    stop_hit    = (scaled_hit <= tol_n_q);
    stop_miss   = (scaled_miss <= tol_n_q);
    rose_hit    = (cnt_hit > pcc_q);
    rose_miss   = (ecc_q > pcc_q);
  end

  // second stage: verdict and epoch bookkeeping
  always_comb begin
    correct     = (nonneg == pos_q);
    closed      = correct ? cnt_hit : ecc_q;
    ex_next     = ex_q + CW'(1);
    ep_next     = ep_q + CW'(1);
    ended       = (ex_next >= n_eff);
    stop        = ended && (correct ? stop_hit : stop_miss);
    gave        = ended && !stop && (ep_next >= me_eff);
    rose        = correct ? rose_hit : rose_miss;
  end

  // lane commands
  always_comb begin
    ctl.load    = in_acc && (in_i.op == pot_pkg::OP_LOAD);
    ctl.capture = in_acc && (in_i.op == pot_pkg::OP_EXAMPLE)
                  && (status_q == pot_pkg::ST_TRAIN);
    ctl.update  = fire && !correct;
    ctl.add     = pos_q;
    // on a stop without gain the old snapshot is sent first, copied after
    ctl.copy    = (fire && ended && !(stop && !rose)) || (emit_step && emit_last);
  end

  // next status
  always_comb begin
    status_d = status_q;
    if (ctl.load) begin
      status_d = pot_pkg::ST_TRAIN;
    end else if (fire && stop) begin
      status_d = pot_pkg::ST_DONE;
    end else if (fire && gave) begin
      status_d = pot_pkg::ST_FAIL;
    end
  end

  // weight word being emitted
  assign wsel_ext = 64'(prior[emit_idx_q]);

  // next output word
  always_comb begin
    out_d = out_q;
    if (fire) begin
      out_d.kind          = pot_pkg::KIND_VERDICT;
      out_d.correct       = correct;
      out_d.epoch_end     = ended;
      out_d.epoch_correct = ended ? closed : '0;
      out_d.gave_up       = gave;
      out_d.weight_index  = '0;
      out_d.weight_out    = '0;
      out_d.last          = !stop;
    end else if (emit_step) begin
      out_d.kind          = pot_pkg::KIND_WEIGHT;
      out_d.correct       = 1'b0;
      out_d.epoch_end     = 1'b0;
      out_d.epoch_correct = '0;
      out_d.gave_up       = 1'b0;
      out_d.weight_index  = pot_pkg::INDEX_BITS'(emit_idx_q);
      out_d.weight_out    = wsel_ext[pot_pkg::LOAD_BITS-1:0];
      out_d.last          = emit_last;
    end
  end

  // control and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q        <= 1'b0;
      ecc_q       <= '0;
      pcc_q       <= '0;
      ex_q        <= '0;
      ep_q        <= '0;
      status_q    <= pot_pkg::ST_TRAIN;
      emit_q      <= 1'b0;
      emit_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      status_q <= status_d;
      if (ctl.capture) begin
        s1_q <= 1'b1;
      end else if (fire) begin
        s1_q <= 1'b0;
      end
      if (ctl.load) begin
        ecc_q <= '0;
        pcc_q <= '0;
        ex_q  <= '0;
        ep_q  <= '0;
      end else if (fire) begin
        if (ended) begin
          ecc_q <= '0;
          pcc_q <= closed;
          ex_q  <= '0;
          ep_q  <= ep_next;
        end else begin
          ecc_q <= closed;
          ex_q  <= ex_next;
        end
      end
      // weight word sequencer
      if (fire && stop) begin
        emit_q     <= 1'b1;
        emit_idx_q <= '0;
      end else if (emit_step) begin
        emit_idx_q <= emit_idx_q + EIDX_W'(1);
        if (emit_last) begin
          emit_q <= 1'b0;
        end
      end
      // output register
      if (fire || emit_step) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (ctl.capture) begin
      pos_q <= in_i.is_positive;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.kind          = out_q.kind;
  assign out_o.correct       = out_q.correct;
  assign out_o.epoch_end     = out_q.epoch_end;
  assign out_o.epoch_correct = out_q.epoch_correct;
  assign out_o.gave_up       = out_q.gave_up;
  assign out_o.weight_index  = out_q.weight_index;
  assign out_o.weight_out    = out_q.weight_out;
  assign out_o.last          = out_q.last;

`ifndef SYNTHESIS
  // an example and the weight sequencer never share the second stage
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s1_q && emit_q))
    else $error("example in flight while weight words are emitted");

  // a stop hands over to the weight sequencer
  a_stop_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && stop) |=> (emit_q && emit_idx_q == '0 && status_q == pot_pkg::ST_DONE))
    else $error("stop did not start weight emission");

  // examples taken after training ends produce no work
  a_idle_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.op == pot_pkg::OP_EXAMPLE && status_q != pot_pkg::ST_TRAIN)
    |=> !s1_q)
    else $error("example accepted after training ended");

  // weight words carry an index inside the weight vector
  a_emit_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.kind == pot_pkg::KIND_WEIGHT)
    |-> (out_q.weight_index <= pot_pkg::INDEX_BITS'(NL - 1)))
    else $error("weight index out of range");
`endif

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// Testbench for perceptron_online_trainer: drives loads and examples over the
// input channel and checks every result word against an in-bench model.
// Depends on pot_pkg, pot_if and the trainer RTL.
module tb;
  import pot_pkg::*;

  localparam int     NW            = NUM_FEATURES_DEF + 1;
  localparam int     FB            = FEATURE_BITS_DEF;
  localparam longint W_MAX         = (longint'(1) <<< (WEIGHT_BITS_DEF - 1)) - 1;
  localparam longint W_MIN         = -W_MAX - 1;
  localparam int     IDLE_PCT      = 26;
  localparam int     SETTLE_CYCLES = 6;
  localparam int     END_SETTLE    = 24;
  localparam int     ITEM_TARGET   = 265;
  localparam int     CYCLE_LIMIT   = 400000;

  typedef enum logic [1:0] {ACT_ITEM, ACT_CFG, ACT_HOLD} act_e;

  typedef struct {
    act_e        act;
    logic        op;
    logic [63:0] features;
    logic        is_positive;
    logic [4:0]  load_index;
    logic [31:0] load_value;
    cfg_idx_e    cfg_idx;
    logic [15:0] cfg_data;
  } stim_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we;
  cfg_idx_e    cfg_index;
  logic [15:0] cfg_wdata;

  pot_in_if  in_ch ();
  pot_out_if out_ch ();

  perceptron_online_trainer i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Pending stimulus and predicted result words
  stim_t     to_send [$];
  out_word_t predicted_words [$];

  // Model copy of the configuration registers
  logic [15:0] rate_q      = RATE_RST;
  logic [15:0] epoch_len_q = EPOCH_N_RST;
  logic [15:0] max_ep_q    = MAX_EP_RST;
  logic [9:0]  tol_q       = TOL_RST;

  // Model copy of the training state
  longint      w_cur [NW];
  longint      w_prev [NW];
  int unsigned hits_cnt, prior_hits, ex_in_epoch, epoch_num;
  run_status_e train_state;

  // Bookkeeping
  int unsigned items_queued, items_taken, mismatches, cycles, settle;
  int unsigned n_loads, n_graded, n_epochs, n_stops, n_giveups, n_ignored, n_cfg;
  int unsigned n_weight_words;
  bit          in_fired, calm;
  int          teacher [NW];

  function automatic longint clip_weight(longint v);
    if (v > W_MAX) return W_MAX;
    if (v < W_MIN) return W_MIN;
    return v;
  endfunction

  // Append to the tail of the expected and pending queues
  function automatic void add_expected(out_word_t w);
    predicted_words.insert(predicted_words.size(), w);
  endfunction

  function automatic void add_stim(stim_t s);
    to_send.insert(to_send.size(), s);
  endfunction

  // Predict the result words of one accepted input word
  task automatic learn_from(logic op, logic [63:0] feat, logic pos,
                            logic [4:0] lidx, logic [31:0] lval);
    longint      xv [NW];
    longint      acc, src;
    logic        hit, ended, stop, gave;
    int unsigned len, lim, closed, diff;
    out_word_t   wd;
    if (op == OP_LOAD) begin
      if (lidx < NW) begin
        w_cur[lidx]  = clip_weight(longint'(signed'(lval)));
        w_prev[lidx] = w_cur[lidx];
      end
      hits_cnt    = 0;
      prior_hits  = 0;
      ex_in_epoch = 0;
      epoch_num   = 0;
      train_state = ST_TRAIN;
      n_loads++;
      return;
    end
    if (train_state != ST_TRAIN) begin
      n_ignored++;
      return;
    end

    // Classify: bias feature is 1, zero sum counts as positive
    xv[0] = 1;
    acc   = w_cur[0];
    for (int k = 1; k < NW; k++) begin
      xv[k] = longint'(feat[FB*(k-1) +: FB]);
      acc  += w_cur[k] * xv[k];
    end
    hit = ((acc >= 0) == pos);

    if (hit) begin
      if (hits_cnt < 16'hFFFF) hits_cnt++;
    end else begin
      for (int k = 0; k < NW; k++)
        w_cur[k] = clip_weight(pos ? w_cur[k] + longint'(rate_q) * xv[k]
                                   : w_cur[k] - longint'(rate_q) * xv[k]);
    end

    // Epoch bookkeeping and stop rule
    len         = (epoch_len_q == 0) ? 1 : epoch_len_q;
    lim         = (max_ep_q == 0) ? 1 : max_ep_q;
    ex_in_epoch = (ex_in_epoch + 1) & 16'hFFFF;
    closed      = hits_cnt;
    ended       = 1'b0;
    stop        = 1'b0;
    gave        = 1'b0;
    if (ex_in_epoch >= len) begin
      ended       = 1'b1;
      ex_in_epoch = 0;
      epoch_num   = (epoch_num + 1) & 16'hFFFF;
      diff        = (closed >= prior_hits) ? closed - prior_hits : prior_hits - closed;
      if (longint'(diff) * STOP_SCALE <= longint'(tol_q) * len) begin
        stop        = 1'b1;
        train_state = ST_DONE;
      end else if (epoch_num >= lim) begin
        gave        = 1'b1;
        train_state = ST_FAIL;
      end
    end

    wd               = '0;
    wd.kind          = KIND_VERDICT;
    wd.correct       = hit;
    wd.epoch_end     = ended;
    wd.epoch_correct = ended ? closed[15:0] : '0;
    wd.gave_up       = gave;
    wd.last          = !stop;
    add_expected(wd);
    n_graded++;
    n_epochs  += ended;
    n_giveups += gave;

    // Final weights: current if accuracy rose, else the previous epoch's
    if (stop) begin
      n_stops++;
      for (int k = 0; k < NW; k++) begin
        src             = (closed > prior_hits) ? w_cur[k] : w_prev[k];
        wd              = '0;
        wd.kind         = KIND_WEIGHT;
        wd.weight_index = INDEX_BITS'(k);
        wd.weight_out   = src[31:0];
        wd.last         = (k == NW - 1);
        add_expected(wd);
      end
    end
    if (ended) begin
      w_prev     = w_cur;
      prior_hits = closed;
      hits_cnt   = 0;
    end
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // Stimulus builders
  task automatic push_item(logic op, logic [63:0] f, logic pos, logic [4:0] idx,
                           logic [31:0] val);
    stim_t s;
    s             = '{default: '0, act: ACT_ITEM, cfg_idx: CFG_LEARNING_RATE};
    s.op          = op;
    s.features    = f;
    s.is_positive = pos;
    s.load_index  = idx;
    s.load_value  = val;
    add_stim(s);
    items_queued++;
  endtask

  task automatic push_example(logic [63:0] f, logic pos);
    push_item(OP_EXAMPLE, f, pos, 5'($urandom), $urandom);
  endtask

  task automatic push_load(logic [4:0] idx, logic [31:0] val);
    push_item(OP_LOAD, {$urandom, $urandom}, 1'($urandom), idx, val);
  endtask

  task automatic push_cfg(cfg_idx_e idx, logic [15:0] data);
    stim_t s;
    s          = '{default: '0, act: ACT_CFG, cfg_idx: idx};
    s.cfg_data = data;
    add_stim(s);
  endtask

  task automatic push_hold();
    stim_t s;
    s = '{default: '0, act: ACT_HOLD, cfg_idx: CFG_LEARNING_RATE};
    add_stim(s);
  endtask

  task automatic wait_sent(bit drained);
    do @(negedge clk_i);
    while (to_send.size() != 0 || items_taken != items_queued ||
           (drained && predicted_words.size() != 0));
  endtask

  // Driver: one word per handshake, random gaps, register writes when idle
  always @(negedge clk_i) begin
    logic  next_valid;
    logic  next_we;
    stim_t head;
    if (rst_ni) begin
      next_we = 1'b0;
      if (!in_ch.valid || in_fired) begin
        next_valid = 1'b0;
        in_fired   = 1'b0;
        if (to_send.size() != 0) begin
          head = to_send[0];
          if (head.act == ACT_ITEM) begin
            if (calm || $urandom_range(99) >= IDLE_PCT) begin
              in_ch.op          <= head.op;
              in_ch.features    <= head.features;
              in_ch.is_positive <= head.is_positive;
              in_ch.load_index  <= head.load_index;
              in_ch.load_value  <= head.load_value;
              next_valid = 1'b1;
              void'(to_send.pop_front());
            end
          end else if (predicted_words.size() != 0) begin
            settle = 0;
          end else if (settle < SETTLE_CYCLES) begin
            settle++;
          end else begin
            settle = 0;
            if (head.act == ACT_CFG) begin
              next_we = 1'b1;
              cfg_index <= head.cfg_idx;
              cfg_wdata <= head.cfg_data;
              case (head.cfg_idx)
                CFG_LEARNING_RATE: rate_q      = head.cfg_data;
                CFG_EPOCH_LEN:     epoch_len_q = head.cfg_data;
                CFG_MAX_EPOCHS:    max_ep_q    = head.cfg_data;
                CFG_TOLERANCE:     tol_q       = head.cfg_data[9:0];
                default: ;
              endcase
              n_cfg++;
            end
            void'(to_send.pop_front());
          end
        end
        in_ch.valid <= next_valid;
      end
      cfg_we <= next_we;
      out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Monitor: predict on input handshakes, compare on output handshakes
  always @(posedge clk_i) begin
    out_word_t exp_w;
    if (rst_ni) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $error("timeout with %0d result words outstanding", predicted_words.size());
        $display("DONE: errors detected");
        $finish;
      end else begin
        if (in_ch.valid && in_ch.ready) begin
          in_fired = 1'b1;
          items_taken++;
          learn_from(in_ch.op, in_ch.features, in_ch.is_positive, in_ch.load_index,
                     in_ch.load_value);
        end
        if (out_ch.valid && out_ch.ready) begin
          if (predicted_words.size() == 0) begin
            $error("unexpected result word: kind %0d index %0d value 0x%0h",
                   out_ch.kind, out_ch.weight_index, out_ch.weight_out);
            mismatches++;
          end else begin
            exp_w = predicted_words.pop_front();
            check_field("kind", exp_w.kind, out_ch.kind);
            check_field("correct", exp_w.correct, out_ch.correct);
            check_field("epoch_end", exp_w.epoch_end, out_ch.epoch_end);
            check_field("epoch_correct", exp_w.epoch_correct, out_ch.epoch_correct);
            check_field("gave_up", exp_w.gave_up, out_ch.gave_up);
            check_field("weight_index", exp_w.weight_index, out_ch.weight_index);
            check_field("weight_out", exp_w.weight_out, out_ch.weight_out);
            check_field("last", exp_w.last, out_ch.last);
          end
        end
        // no gaps on either side for a stretch in the middle of the run
        calm = (items_taken >= 120 && items_taken < 200);
      end
    end
  end

  initial begin
    logic [15:0] v16;
    logic [31:0] wval;
    logic [63:0] f;
    int          score, pick, n_ex;
    logic        lbl;

    rst_ni            = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = CFG_LEARNING_RATE;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.op          = OP_LOAD;
    in_ch.features    = '0;
    in_ch.is_positive = 1'b0;
    in_ch.load_index  = '0;
    in_ch.load_value  = '0;
    out_ch.ready      = 1'b0;
    train_state       = ST_TRAIN;
    for (int k = 0; k < NW; k++) begin
      w_cur[k]  = 0;
      w_prev[k] = 0;
    end

    // Directed: zero sum counts as positive, then a miss on the bias
    push_example(64'd0, 1'b1);
    push_example(64'd0, 1'b0);
    // Extreme weights, ignored slots, zero epoch settings, stop beats limit
    push_cfg(CFG_LEARNING_RATE, 16'hFFFF);
    push_cfg(CFG_EPOCH_LEN, 16'd0);
    push_cfg(CFG_MAX_EPOCHS, 16'd0);
    push_cfg(CFG_TOLERANCE, 16'd1023);
    push_load(5'd0, 32'h7FFF_FFFF);
    push_load(5'd16, 32'h8000_0000);
    push_load(5'd31, 32'h1234_5678);
    push_load(5'd17, 32'hFFFF_FFFF);
    push_example({64{1'b1}}, 1'b1);
    push_example({64{1'b1}}, 1'b0);  // after the stop: dropped
    // Tight tolerance, one epoch allowed
    push_cfg(CFG_TOLERANCE, 16'd0);
    push_cfg(CFG_EPOCH_LEN, 16'd2);
    push_cfg(CFG_MAX_EPOCHS, 16'd1);
    push_load(5'd1, 32'd0);
    push_example(64'd1, 1'b0);
    push_example({64{1'b1}}, 1'b1);
    push_example(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
    // Slowest rate, loose tolerance, epoch limit at its top
    push_cfg(CFG_LEARNING_RATE, 16'd1);
    push_cfg(CFG_EPOCH_LEN, 16'd3);
    push_cfg(CFG_MAX_EPOCHS, 16'hFFFF);
    push_cfg(CFG_TOLERANCE, 16'd1000);
    push_load(5'd0, 32'd0);
    push_example(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    push_example(64'h5555_5555_5555_5555, 1'b1);
    push_hold();
    push_example(64'hF0F0_F0F0_F0F0_F0F0, 1'b0);
    push_example(64'h0F0F_0F0F_0F0F_0F0F, 1'b1);

    repeat (12) @(posedge clk_i);
    #3 rst_ni = 1'b1;
    wait_sent(1'b0);

    // Random sessions: new settings, a restart, then examples from a
    // hidden linear rule with some label noise and stray loads
    while (items_queued < ITEM_TARGET) begin
      @(posedge clk_i);
      pick = $urandom_range(5);
      v16  = (pick == 0) ? 16'd1 : (pick == 1) ? 16'hFFFF : 16'($urandom_range(65535, 1));
      push_cfg(CFG_LEARNING_RATE, v16);
      pick = $urandom_range(19);
      v16  = (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF : (pick == 2) ? 16'd1 :
             16'($urandom_range(8, 2));
      push_cfg(CFG_EPOCH_LEN, v16);
      pick = $urandom_range(9);
      v16  = (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF : 16'($urandom_range(6, 1));
      push_cfg(CFG_MAX_EPOCHS, v16);
      pick = $urandom_range(9);
      v16  = (pick == 0) ? 16'd0 : (pick == 1) ? 16'd1000 : (pick == 2) ? 16'd1023 :
             {6'($urandom), 10'($urandom_range(300))};
      push_cfg(CFG_TOLERANCE, v16);

      // restart with a few or all slots loaded
      pick = $urandom_range(3);
      for (int k = 0; k < NW; k++) begin
        if (pick == 0 || $urandom_range(7) == 0) begin
          wval = ($urandom_range(9) == 0) ? $urandom :
                 32'($urandom_range(32'h0020_0000)) - 32'h0010_0000;
          push_load(5'(k), wval);
        end
      end
      push_load(5'($urandom), $urandom);

      for (int k = 0; k < NW; k++) teacher[k] = int'($urandom_range(16)) - 8;
      n_ex = $urandom_range(40, 8);
      for (int e = 0; e < n_ex; e++) begin
        f     = {$urandom, $urandom};
        score = teacher[0] * 8;
        for (int k = 1; k < NW; k++) score += teacher[k] * int'(f[FB*(k-1) +: FB]);
        lbl = (score >= 0);
        if ($urandom_range(9) == 0) lbl = !lbl;
        push_example(f, lbl);
        if ($urandom_range(39) == 0) push_load(5'($urandom), $urandom);
        if ($urandom_range(29) == 0) push_hold();
      end
      wait_sent(1'b0);
    end

    // Drain and let any stray word show up
    wait_sent(1'b1);
    repeat (END_SETTLE) @(negedge clk_i);

    $display("Covered %0d loads, %0d graded examples over %0d epoch ends, %0d register writes.",
             n_loads, n_graded, n_epochs, n_cfg);
    $display("Training stopped %0d times and gave up %0d times; %0d examples came after the end.",
             n_stops, n_giveups, n_ignored);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: perceptron_online_trainer.f
sv/pot_pkg.sv
sv/pot_if.sv
sv/pot_lane.sv
sv/pot_merge.sv
sv/perceptron_online_trainer.sv
dv/tb.sv
